>>> rtl/core/lkvc_pkg.sv
package lkvc_pkg;

    // Cache geometry
    localparam int MAX_ENTRIES = 16;
    localparam int KEY_W       = 32;
    localparam int DATA_W      = 32;
    localparam int CAP_W       = 5;
    localparam int AGE_W       = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
    localparam int CMP_W       = (CNT_W > CAP_W) ? CNT_W : CAP_W;

    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

    // Access kinds
    localparam logic MODE_GET = 1'b0;
    localparam logic MODE_PUT = 1'b1;

    // Result status codes
    typedef enum logic [2:0] {
        ST_HIT   = 3'd0,
        ST_MISS  = 3'd1,
        ST_INSERT = 3'd2,
        ST_EVICT = 3'd3,
        ST_ERROR = 3'd4
    } status_t;

    // Operation broadcast to every cell
    typedef enum logic [1:0] {
        OP_NONE,
        OP_TOUCH,
        OP_INSERT,
        OP_EVICT
    } cell_op_t;

    typedef struct packed {
        logic               mode;
        logic signed [31:0] key;
        logic signed [31:0] value;
    } in_item_t;

    typedef struct packed {
        status_t            status;
        logic signed [31:0] read_value;
    } out_item_t;

    // Command from the controller to all cells
    typedef struct packed {
        cell_op_t           op;
        logic               write_data;
        logic [AGE_W-1:0]   ref_age;
        logic [AGE_W-1:0]   oldest_age;
    } cell_cmd_t;

    // Link passed from one cell to its right neighbor
    typedef struct packed {
        logic               hit_seen;
        logic [DATA_W-1:0]  hit_data;
        logic [AGE_W-1:0]   hit_age;
        logic               free_seen;
    } cell_link_t;

endpackage

>>> rtl/core/lkvc_cell.sv
module lkvc_cell
    import lkvc_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic [KEY_W-1:0]  req_key,
    input  logic [DATA_W-1:0] req_value,
    input  cell_cmd_t         cmd,
    input  cell_link_t        link_in,
    output cell_link_t        link_out
);

    logic              valid_reg, valid_next;
    logic [AGE_W-1:0]  age_reg, age_next;
    logic [KEY_W-1:0]  key_reg, key_next;
    logic [DATA_W-1:0] data_reg, data_next;

    logic match;
    logic claim;
    logic oldest;
    logic [AGE_W-1:0] age_inc;

    // Local compare and slot selection
    assign match   = valid_reg && (key_reg == req_key);
    assign claim   = !valid_reg && !link_in.free_seen;
    assign oldest  = valid_reg && (age_reg == cmd.oldest_age);
    assign age_inc = age_reg + AGE_W'(1);

    // Pass hit and free-slot results to the neighbor
    always_comb begin
        link_out.hit_seen  = link_in.hit_seen | match;
        link_out.hit_data  = match ? data_reg : link_in.hit_data;
        link_out.hit_age   = match ? age_reg : link_in.hit_age;
        link_out.free_seen = link_in.free_seen | !valid_reg;
    end

    // Apply the broadcast operation to this entry
    always_comb begin
        valid_next = valid_reg;
        age_next   = age_reg;
        key_next   = key_reg;
        data_next  = data_reg;
        case (cmd.op)
            OP_TOUCH: begin
                if (match) begin
                    age_next = '0;
                    if (cmd.write_data) begin
                        data_next = req_value;
                    end
                end else if (valid_reg && (age_reg < cmd.ref_age)) begin
                    age_next = age_inc;
                end
            end
            OP_INSERT: begin
                if (claim) begin
                    valid_next = 1'b1;
                    age_next   = '0;
                    key_next   = req_key;
                    data_next  = req_value;
                end else if (valid_reg) begin
                    age_next = age_inc;
                end
            end
            OP_EVICT: begin
                if (oldest) begin
                    age_next  = '0;
                    key_next  = req_key;
                    data_next = req_value;
                end else if (valid_reg) begin
                    age_next = age_inc;
                end
            end
            default: begin
            end
        endcase
    end

    // Hold valid and rank
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            age_reg   <= '0;
        end else begin
            valid_reg <= valid_next;
            age_reg   <= age_next;
        end
    end

    // Hold key and data
    always_ff @(posedge aclk) begin
        key_reg  <= key_next;
        data_reg <= data_next;
    end

endmodule

>>> rtl/core/lru_key_value_cache_core.sv
// Fully associative key/value cache with least-recently-used replacement.
// Input channel (s_valid/s_ready/s_data): one transaction per access, mode
// 0 looks a key up, mode 1 stores a key/value pair. Result channel
// (m_valid/m_ready/m_data): exactly one transaction per access, carrying a
// status and the read value (zero except on a lookup hit).
// Timing: an access accepted in S_IDLE is resolved in S_EXEC in the
// following cycle, where every cell compares its key and the row passes
// hit and free-slot results cell to cell before all cells update
// together; its result then goes into the output register on commit.
// A finished result sits in an output register; a new access is taken
// while it waits. If the receiver still stalls when the next access is
// resolved, that access holds in S_EXEC until the output frees.
// Capacity is written through cfg_wr_en/cfg_wr_data; the user must write
// it only while the cache is idle, which the block does not enforce.
// Values above the entry count saturate, zero fails every access.
// Reset (aresetn low, synchronous): all entries invalid, capacity 16, no
// result pending. Entries need no clearing pass.
module lru_key_value_cache_core
    import lkvc_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cfg_wr_en,
    input  logic [CAP_W-1:0] cfg_wr_data,
    input  logic             s_valid,
    output logic             s_ready,
    input  in_item_t         s_data,
    output logic             m_valid,
    input  logic             m_ready,
    output out_item_t        m_data
);

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } state_t;

    state_t           state_reg;
    logic [CAP_W-1:0] capacity_reg;
    logic [CNT_W-1:0] fill_count_reg, fill_count_next;
    in_item_t         req_reg;
    logic             m_valid_reg;
    out_item_t        m_data_reg, m_data_next;

    cell_link_t link [MAX_ENTRIES+1];
    cell_cmd_t  cmd;

    logic [CMP_W-1:0] cap_ext;
    logic [CMP_W-1:0] cap_eff;
    logic [CMP_W-1:0] fill_ext;
    logic [CNT_W-1:0] fill_minus;
    logic             out_free;
    logic             commit;

    assign s_ready  = (state_reg == S_IDLE);
    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;
    assign out_free = !m_valid_reg || m_ready;
    assign commit   = (state_reg == S_EXEC) && out_free;

    // Saturate capacity at the entry count
    assign cap_ext  = CMP_W'(capacity_reg);
    assign cap_eff  = (cap_ext > CMP_W'(MAX_ENTRIES)) ? CMP_W'(MAX_ENTRIES) : cap_ext;
    assign fill_ext = CMP_W'(fill_count_reg);
    assign fill_minus = fill_count_reg - CNT_W'(1);

    // Row of cells, results flowing left to right
    assign link[0] = '0;

    for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
        lkvc_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .req_key   (req_reg.key),
            .req_value (req_reg.value),
            .cmd       (cmd),
            .link_in   (link[i]),
            .link_out  (link[i+1])
        );
    end

    // Resolve the access and build the cell command
    always_comb begin
        cmd.op          = OP_NONE;
        cmd.write_data  = req_reg.mode;
        cmd.ref_age     = link[MAX_ENTRIES].hit_age;
        cmd.oldest_age  = fill_minus[AGE_W-1:0];
        fill_count_next = fill_count_reg;
        m_data_next.status     = ST_ERROR;
        m_data_next.read_value = '0;
        if (cap_eff == '0) begin
            m_data_next.status = ST_ERROR;
        end else if (link[MAX_ENTRIES].hit_seen) begin
            m_data_next.status = ST_HIT;
            cmd.op = OP_TOUCH;
            if (req_reg.mode == MODE_GET) begin
                m_data_next.read_value = link[MAX_ENTRIES].hit_data;
            end
        end else if (req_reg.mode == MODE_GET) begin
            m_data_next.status = ST_MISS;
        end else if (fill_ext < cap_eff) begin
            m_data_next.status = ST_INSERT;
            cmd.op = OP_INSERT;
            fill_count_next = fill_count_reg + CNT_W'(1);
        end else begin
            m_data_next.status = ST_EVICT;
            cmd.op = OP_EVICT;
        end
        if (!commit) begin
            cmd.op          = OP_NONE;
            fill_count_next = fill_count_reg;
        end
    end

    // State, request, fill count and result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            capacity_reg   <= CAP_RESET;
            fill_count_reg <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                capacity_reg <= cfg_wr_data;
            end
            fill_count_reg <= fill_count_next;
            case (state_reg)
                S_IDLE: begin
                    if (s_valid) begin
                        req_reg   <= s_data;
                        state_reg <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    if (commit) begin
                        state_reg <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
            if (commit) begin
                m_valid_reg <= 1'b1;
                m_data_reg  <= m_data_next;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

endmodule
